FILE: hw/rtl/dmwbc_pkg.sv
// package for the direct-mapped write-back data cache
// holds word types, line entry layout, result codes, controller states and lane helpers
// no dependencies
package dmwbc_pkg;

    // fixed geometry and charges
    localparam int          LINE_BITS   = 128;
    localparam int          TAG_BITS    = 20;
    localparam logic [7:0]  HIT_CYCLES  = 8'd2;
    localparam logic [7:0]  MISS_CYCLES = 8'd80;

    // result kinds
    localparam logic [2:0] KIND_READ_DATA  = 3'd0;
    localparam logic [2:0] KIND_WRITE_DONE = 3'd1;
    localparam logic [2:0] KIND_WRITEBACK  = 3'd2;
    localparam logic [2:0] KIND_FILL       = 3'd3;
    localparam logic [2:0] KIND_BUS_WRITE  = 3'd4;

    // access sizes
    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_HALF  = 2'd1;
    localparam logic [1:0] SIZE_WORD  = 2'd2;
    localparam logic [1:0] SIZE_DWORD = 2'd3;

    // request word
    typedef struct packed {
        logic [1:0]  req_type;
        logic [8:0]  virt_set;
        logic [31:0] phys_address;
        logic [1:0]  access_size;
        logic [63:0] write_data;
        logic [63:0] mem_line_upper;
        logic [63:0] mem_line_lower;
    } req_t;

    // result word
    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] bus_address;
        logic [63:0] data_upper;
        logic [63:0] data_lower;
        logic [7:0]  charged_cycles;
        logic        last_result;
    } rsp_t;

    // one cache entry as stored in the array
    typedef struct packed {
        logic                 valid;
        logic                 dirty;
        logic [TAG_BITS-1:0]  tag;
        logic [LINE_BITS-1:0] data;
    } line_t;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_FILL,
        ST_FINAL
    } state_t;

    // low bytes kept for a given access size
    function automatic logic [63:0] size_mask(input logic [1:0] size);
        logic [63:0] m;
        case (size)
            SIZE_BYTE:  m = 64'h0000_0000_0000_00ff;
            SIZE_HALF:  m = 64'h0000_0000_0000_ffff;
            SIZE_WORD:  m = 64'h0000_0000_ffff_ffff;
            SIZE_DWORD: m = 64'hffff_ffff_ffff_ffff;
            default:    m = 64'hffff_ffff_ffff_ffff;
        endcase
        return m;
    endfunction

    // bit shift that brings an aligned big-endian lane down to bit 0
    function automatic logic [7:0] lane_shift(input logic [3:0] addr_lo,
                                              input logic [1:0] size);
        logic [4:0] nbytes;
        logic [4:0] off;
        logic [4:0] right;
        nbytes = 5'd1 << size;
        off    = {1'b0, addr_lo} & ~(nbytes - 5'd1);
        right  = 5'd16 - off - nbytes;
        return {right, 3'b000};
    endfunction

    // zero-extended lane read
    function automatic logic [63:0] lane_read(input logic [LINE_BITS-1:0] line,
                                              input logic [3:0] addr_lo,
                                              input logic [1:0] size);
        logic [LINE_BITS-1:0] shifted;
        shifted = line >> lane_shift(addr_lo, size);
        return shifted[63:0] & size_mask(size);
    endfunction

    // lane merge of store data into a line
    function automatic logic [LINE_BITS-1:0] lane_write(input logic [LINE_BITS-1:0] line,
                                                        input logic [3:0] addr_lo,
                                                        input logic [1:0] size,
                                                        input logic [63:0] wd);
        logic [LINE_BITS-1:0] m;
        logic [LINE_BITS-1:0] d;
        m = {64'd0, size_mask(size)} << lane_shift(addr_lo, size);
        d = {64'd0, wd & size_mask(size)} << lane_shift(addr_lo, size);
        return (line & ~m) | d;
    endfunction

endpackage

FILE: hw/rtl/direct_mapped_writeback_dcache_top.sv
// direct-mapped write-back data cache: line array, lookup and result sequencing
// depends on dmwbc_pkg for word types, entry layout, codes and lane helpers
//
// channel   | direction | handshake              | word
// ----------+-----------+------------------------+--------------------
// request   | in        | start high, busy low   | req  (dmwbc_pkg::req_t)
// result    | out       | rsp_valid, one cycle   | rsp  (dmwbc_pkg::rsp_t)
//
// a hit goes through the registered array read and then the lookup state, which writes
// the entry back and registers the final result; a non-debug miss gives one result a cycle
// (writeback if the victim is dirty, fill request, final result) on the single result port.
// after reset the array is swept clear, one set a cycle, with busy high until every set is cleared.
// results cannot be stalled; the next request is taken in the cycle the final result shows.
module direct_mapped_writeback_dcache_top #(
    parameter int NUM_SETS = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  dmwbc_pkg::req_t   req,
    output logic              rsp_valid,
    output dmwbc_pkg::rsp_t   rsp
);

    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

    // set selector wrapped modulo NUM_SETS by shifted compare and subtract
    function automatic logic [SET_W-1:0] wrap_set(input logic [8:0] v);
        logic [8:0]  r;
        logic [11:0] full;
        r = v;
        for (int i = 8; i >= 0; i--) begin
            if (int'(r) >= (NUM_SETS << i)) begin
                r = r - 9'(NUM_SETS << i);
            end
        end
        full = 12'(r);
        return full[SET_W-1:0];
    endfunction

    // line array
    dmwbc_pkg::line_t mem [NUM_SETS];

    dmwbc_pkg::state_t state_reg, state_next;
    logic [SET_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic              out_valid_reg, out_valid_next;
    dmwbc_pkg::rsp_t   rsp_reg, rsp_next;
    dmwbc_pkg::rsp_t   fill_rsp_reg, final_rsp_reg;
    dmwbc_pkg::req_t   req_reg;
    logic [SET_W-1:0]  set_reg;
    dmwbc_pkg::line_t  rd_q;

    logic              accept;
    logic [SET_W-1:0]  rd_addr;
    logic              mem_we;
    logic [SET_W-1:0]  mem_waddr;
    dmwbc_pkg::line_t  mem_wdata;

    logic                 is_debug;
    logic                 is_write;
    logic [19:0]          req_tag;
    logic [7:0]           set_lo;
    logic                 hit;
    logic                 need_wb;
    logic [127:0]         base_line;
    logic [63:0]          wd_masked;
    logic [7:0]           cyc;
    dmwbc_pkg::line_t     new_entry;
    dmwbc_pkg::rsp_t      wb_rsp, fill_rsp, final_rsp;

    assign accept  = start && (state_reg == dmwbc_pkg::ST_IDLE);
    assign busy    = (state_reg != dmwbc_pkg::ST_IDLE);
    assign rd_addr = wrap_set(req.virt_set);
    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

    // array write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_q <= mem[rd_addr];
    end

    // lookup decode, request type bit 1 marks debug, bit 0 marks write
    always_comb
    begin
        logic [11:0] set_ext;
        set_ext   = 12'(set_reg);
        set_lo    = set_ext[7:0];
        is_debug  = req_reg.req_type[1];
        is_write  = req_reg.req_type[0];
        req_tag   = req_reg.phys_address[31:12];
        hit       = rd_q.valid && (rd_q.tag == req_tag);
        need_wb   = !hit && rd_q.valid && rd_q.dirty;
        base_line = hit ? rd_q.data : {req_reg.mem_line_upper, req_reg.mem_line_lower};
        wd_masked = req_reg.write_data & dmwbc_pkg::size_mask(req_reg.access_size);

        // charged cycles for the final result
        if (is_debug)
        begin
            cyc = 8'd0;
        end
        else if (hit)
        begin
            cyc = dmwbc_pkg::HIT_CYCLES;
        end
        else if (need_wb)
        begin
            cyc = dmwbc_pkg::MISS_CYCLES + dmwbc_pkg::MISS_CYCLES;
        end
        else
        begin
            cyc = dmwbc_pkg::MISS_CYCLES;
        end

        // entry after the access
        new_entry.valid = 1'b1;
        new_entry.dirty = (hit && rd_q.dirty) || is_write;
        new_entry.tag   = req_tag;
        new_entry.data  = is_write
            ? dmwbc_pkg::lane_write(base_line, req_reg.phys_address[3:0],
                                    req_reg.access_size, wd_masked)
            : base_line;

        // writeback of the victim line
        wb_rsp                = '0;
        wb_rsp.result_kind    = dmwbc_pkg::KIND_WRITEBACK;
        wb_rsp.bus_address    = {rd_q.tag, set_lo, 4'h0};
        wb_rsp.data_upper     = rd_q.data[127:64];
        wb_rsp.data_lower     = rd_q.data[63:0];

        // fill request
        fill_rsp              = '0;
        fill_rsp.result_kind  = dmwbc_pkg::KIND_FILL;
        fill_rsp.bus_address  = {req_tag, set_lo, 4'h0};

        // final result
        final_rsp                = '0;
        final_rsp.last_result    = 1'b1;
        final_rsp.charged_cycles = cyc;
        if (is_debug && !hit && is_write)
        begin
            final_rsp.result_kind = dmwbc_pkg::KIND_BUS_WRITE;
            final_rsp.bus_address = req_reg.phys_address;
            final_rsp.data_upper  = wd_masked;
        end
        else if (is_write)
        begin
            final_rsp.result_kind = dmwbc_pkg::KIND_WRITE_DONE;
        end
        else
        begin
            final_rsp.result_kind = dmwbc_pkg::KIND_READ_DATA;
            final_rsp.data_upper  = dmwbc_pkg::lane_read(base_line,
                                        req_reg.phys_address[3:0], req_reg.access_size);
        end
    end

    // next state, result sequencing and array write control
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = 1'b0;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = set_reg;
        mem_wdata      = new_entry;
        case (state_reg)
            dmwbc_pkg::ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SET_W'(NUM_SETS - 1))
                begin
                    state_next = dmwbc_pkg::ST_IDLE;
                end
            end
            dmwbc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = dmwbc_pkg::ST_LOOKUP;
                end
            end
            dmwbc_pkg::ST_LOOKUP:
            begin
                // debug misses and debug hit reads leave the entry alone
                mem_we         = !(is_debug && (!hit || !is_write));
                out_valid_next = 1'b1;
                if (hit || is_debug)
                begin
                    rsp_next   = final_rsp;
                    state_next = dmwbc_pkg::ST_IDLE;
                end
                else if (need_wb)
                begin
                    rsp_next   = wb_rsp;
                    state_next = dmwbc_pkg::ST_FILL;
                end
                else
                begin
                    rsp_next   = fill_rsp;
                    state_next = dmwbc_pkg::ST_FINAL;
                end
            end
            dmwbc_pkg::ST_FILL:
            begin
                out_valid_next = 1'b1;
                rsp_next       = fill_rsp_reg;
                state_next     = dmwbc_pkg::ST_FINAL;
            end
            dmwbc_pkg::ST_FINAL:
            begin
                out_valid_next = 1'b1;
                rsp_next       = final_rsp_reg;
                state_next     = dmwbc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dmwbc_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dmwbc_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (accept)
        begin
            req_reg <= req;
            set_reg <= rd_addr;
        end
        if (state_reg == dmwbc_pkg::ST_LOOKUP)
        begin
            fill_rsp_reg  <= fill_rsp;
            final_rsp_reg <= final_rsp;
        end
    end

    // a result that is not the last is followed by another in the next cycle
    a_chain_continues: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last_result |=> rsp_valid)
        else $error("result sequence broken before its last word");

    // cycles are charged only on the last result
    a_cycles_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last_result |-> rsp.charged_cycles == 8'd0)
        else $error("cycles charged on a non-final result");

    // a writeback is always followed by a fill request
    a_wb_then_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.result_kind == dmwbc_pkg::KIND_WRITEBACK
        |=> rsp_valid && rsp.result_kind == dmwbc_pkg::KIND_FILL)
        else $error("writeback not followed by fill request");

    // no result in the cycle after a request is taken
    a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> !rsp_valid && busy)
        else $error("result shown during lookup");

endmodule
